>>> rtl/otca_pkg.sv
// Shared constants, types and the cell rule function for the automaton row step.
package otca_pkg;

    // Rule and width registers
    localparam int RULE_BITS       = 18;
    localparam int GRID_W_BITS     = 7;
    localparam int MAX_COLUMNS_DEF = 64;
    localparam logic [RULE_BITS-1:0]   RULE_RESET  = 18'd174826;
    localparam logic [GRID_W_BITS-1:0] WIDTH_RESET = 7'd64;

    // Configuration port
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = RULE_BITS;
    localparam logic [CFG_INDEX_W-1:0] REG_RULE_CODE  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH = 8'd1;

    // Bits a cell shows to its left and right neighbors (already masked)
    typedef struct packed {
        logic above;
        logic mid;
        logic row;
    } nbr_t;

    // Per-word cell control
    typedef struct packed {
        logic load;
        logic final_row;
    } cell_ctl_t;

    // Result words pushed into the output queue on one accepted word
    typedef struct packed {
        logic a_en;   // row above the new one is finished
        logic b_en;   // bottom row of the generation is finished
    } push_t;

    // Next state from the eight neighbors and own state
    function automatic logic next_state(input logic [RULE_BITS-1:0] rule,
                                        input logic [7:0] nbrs,
                                        input logic s);
        logic [3:0] n;
        logic [4:0] idx;
        n = 4'd0;
        for (int k = 0; k < 8; k++)
        begin
            n = n + {3'd0, nbrs[k]};
        end
        idx = {n, s};
        return rule[idx];
    endfunction

endpackage

>>> rtl/otca_cell.sv
// One column cell: holds the above and middle bits of its column and evaluates next states.
module otca_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  otca_pkg::cell_ctl_t            ctl,
    input  logic                           active,
    input  logic [otca_pkg::RULE_BITS-1:0] rule,
    input  logic                           row_bit,
    input  otca_pkg::nbr_t                 left,
    input  otca_pkg::nbr_t                 right,
    output otca_pkg::nbr_t                 own,
    output logic                           res_above,
    output logic                           res_final
);
    import otca_pkg::*;

    logic above_reg, above_next;
    logic mid_reg, mid_next;

    // Masked view of this column
    assign own.above = above_reg & active;
    assign own.mid   = mid_reg & active;
    assign own.row   = row_bit & active;

    // Row above the incoming one: above / mid / incoming
    assign res_above = active & next_state(rule,
        {left.above, own.above, right.above, left.mid, right.mid,
         left.row, own.row, right.row}, own.mid);

    // Incoming row as the bottom row: mid / incoming / dead
    assign res_final = active & next_state(rule,
        {left.mid, own.mid, right.mid, left.row, right.row, 3'b000}, own.row);

    // Shift the column down on each word; a final word clears it
    always_comb
    begin
        above_next = above_reg;
        mid_next   = mid_reg;
        if (ctl.load)
        begin
            above_next = ctl.final_row ? 1'b0 : own.mid;
            mid_next   = ctl.final_row ? 1'b0 : own.row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            above_reg <= 1'b0;
            mid_reg   <= 1'b0;
        end
        else
        begin
            above_reg <= above_next;
            mid_reg   <= mid_next;
        end
    end

endmodule

>>> rtl/otca_out_queue.sv
// Three-word shifting output queue that takes up to two result words per cycle.
module otca_out_queue #(
    parameter int DATA_W = otca_pkg::MAX_COLUMNS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  otca_pkg::push_t   push,
    input  logic [DATA_W-1:0] a_data,
    input  logic [DATA_W-1:0] b_data,
    output logic              full,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DATA_W-1:0] out_data,
    output logic              out_done
);
    import otca_pkg::*;

    localparam int DEPTH = 3;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] data_reg [DEPTH];
    logic [DATA_W-1:0] data_next [DEPTH];
    logic [DEPTH-1:0]  done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  base;
    logic [CNT_W-1:0]  nin;
    logic              pop;
    logic [DATA_W-1:0] first_data;
    logic              first_done;

    assign pop  = (cnt_reg != '0) && !out_stall;
    assign base = cnt_reg - CNT_W'(pop);
    assign nin  = CNT_W'(push.a_en) + CNT_W'(push.b_en);
    // Room for two words must remain after this cycle's pop
    assign full = base > CNT_W'(DEPTH - 2);

    assign first_data = push.a_en ? a_data : b_data;
    assign first_done = !push.a_en;

    // Shift down on pop, append new words behind the survivors
    always_comb
    begin
        int unsigned j;
        cnt_next = base + nin;
        for (int i = 0; i < DEPTH; i++)
        begin
            j = (i + 1 < DEPTH) ? i + 1 : i;
            data_next[i] = data_reg[i];
            done_next[i] = done_reg[i];
            if (CNT_W'(i) < base)
            begin
                if (pop)
                begin
                    data_next[i] = data_reg[j];
                    done_next[i] = done_reg[j];
                end
            end
            else if (CNT_W'(i) == base && nin != '0)
            begin
                data_next[i] = first_data;
                done_next[i] = first_done;
            end
            else if (CNT_W'(i) == base + CNT_W'(1) && push.a_en && push.b_en)
            begin
                data_next[i] = b_data;
                done_next[i] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            data_reg[i] <= data_next[i];
        end
        done_reg <= done_next;
    end

    assign out_valid = cnt_reg != '0;
    assign out_data  = data_reg[0];
    assign out_done  = done_reg[0];

endmodule

>>> rtl/outer_totalistic_ca_row_step.sv
// Top level of the streaming outer-totalistic automaton row step.
// The first result word of an input word is valid in the cycle after its accept when no
// older word waits; the second word of a final pair follows it through the queue.
// Throughput: one row word per cycle; the three-word output queue never holds more than
// two words while the receiver takes every word, so input stalls only behind out_stall.
// Reset (async, active low) empties the queue, clears held rows, loads rule 174826, width 64.
module outer_totalistic_ca_row_step #(
    parameter int MAX_COLUMNS = otca_pkg::MAX_COLUMNS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [MAX_COLUMNS-1:0]           row_cells,
    input  logic                             final_row,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [MAX_COLUMNS-1:0]           next_row_cells,
    output logic                             generation_done,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [otca_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [otca_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import otca_pkg::*;

    localparam logic [GRID_W_BITS-1:0] MAX_W = GRID_W_BITS'(MAX_COLUMNS);

    logic [RULE_BITS-1:0]   rule_reg;
    logic [GRID_W_BITS-1:0] width_reg;
    logic                   held_reg, held_next;
    logic [GRID_W_BITS-1:0] width_eff;
    logic [MAX_COLUMNS-1:0] active;
    logic [MAX_COLUMNS-1:0] res_above;
    logic [MAX_COLUMNS-1:0] res_final;
    nbr_t                   nbr_pad [MAX_COLUMNS+2];
    cell_ctl_t              ctl;
    push_t                  push;
    logic                   accept;
    logic                   q_full;

    // Configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_reg  <= RULE_RESET;
            width_reg <= WIDTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_RULE_CODE)
            begin
                rule_reg <= cfg_data[RULE_BITS-1:0];
            end
            else if (cfg_index == REG_GRID_WIDTH)
            begin
                width_reg <= cfg_data[GRID_W_BITS-1:0];
            end
        end
    end

    // Active column mask, width saturated at the column count
    assign width_eff = (width_reg > MAX_W) ? MAX_W : width_reg;

    always_comb
    begin
        for (int c = 0; c < MAX_COLUMNS; c++)
        begin
            active[c] = GRID_W_BITS'(c) < width_eff;
        end
    end

    // Handshake
    assign accept        = in_valid && !in_stall;
    assign in_stall      = q_full;
    assign ctl.load      = accept;
    assign ctl.final_row = final_row;
    assign push.a_en     = accept && held_reg;
    assign push.b_en     = accept && final_row;

    // Any row held in this generation
    always_comb
    begin
        held_next = held_reg;
        if (accept)
        begin
            held_next = !final_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 1'b0;
        end
        else
        begin
            held_reg <= held_next;
        end
    end

    // Chain of column cells, dead columns beyond both edges
    assign nbr_pad[0]             = '0;
    assign nbr_pad[MAX_COLUMNS+1] = '0;

    for (genvar c = 0; c < MAX_COLUMNS; c++)
    begin : g_cell
        otca_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .active    (active[c]),
            .rule      (rule_reg),
            .row_bit   (row_cells[c]),
            .left      (nbr_pad[c]),
            .right     (nbr_pad[c+2]),
            .own       (nbr_pad[c+1]),
            .res_above (res_above[c]),
            .res_final (res_final[c])
        );
    end

    // Result words
    otca_out_queue #(
        .DATA_W (MAX_COLUMNS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .a_data    (res_above),
        .b_data    (res_final),
        .full      (q_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (next_row_cells),
        .out_done  (generation_done)
    );

endmodule

>>> rtl/otca_checker.sv
// Port-level checker for the automaton row step, bound to the top level.
module otca_checker #(
    parameter int MAX_COLUMNS = otca_pkg::MAX_COLUMNS_DEF
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic                   final_row,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [MAX_COLUMNS-1:0] next_row_cells,
    input logic                   generation_done
);

    // A stalled result word stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(next_row_cells) && $stable(generation_done))
        else $error("result word changed while stalled");

    // A final row always produces at least one result word
    a_final_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && final_row |=> out_valid)
        else $error("final row produced no result");

    // No result word appears from nothing
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && !(in_valid && !in_stall) |=> !out_valid)
        else $error("result word without input word");

endmodule

bind outer_totalistic_ca_row_step otca_checker #(
    .MAX_COLUMNS (MAX_COLUMNS)
) u_otca_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .final_row       (final_row),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .next_row_cells  (next_row_cells),
    .generation_done (generation_done)
);

>>> test/outer_totalistic_ca_row_step_test.sv
// Self-checking testbench for the streaming outer-totalistic automaton row step.
module outer_totalistic_ca_row_step_test;
    import otca_pkg::*;

    localparam int COLS = MAX_COLUMNS_DEF;
    localparam int QUIET_LIMIT = 1000;
    localparam logic [CFG_INDEX_W-1:0] REG_STRAY_FIRST = REG_GRID_WIDTH + 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_STRAY_LAST  = 8'hFF;
    localparam logic [COLS-1:0] ALL_LIVE = {COLS{1'b1}};

    // One next-generation row word as it leaves the block
    typedef struct packed {
        logic [COLS-1:0] cells;
        logic            done;
    } row_word_t;

    // Keeps its own copy of the rule, width and buffered rows; queues the rows
    // each accepted input word finishes and checks result words against them.
    class generation_tracker;
        logic [RULE_BITS-1:0]   rule;
        logic [GRID_W_BITS-1:0] width;
        logic [COLS-1:0]        above;
        logic [COLS-1:0]        middle;
        int unsigned            held;
        row_word_t              expected_rows[$];
        int unsigned            errors;

        function new();
            rule   = RULE_RESET;
            width  = WIDTH_RESET;
            above  = '0;
            middle = '0;
            held   = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_RULE_CODE)
                rule = data[RULE_BITS-1:0];
            else if (idx == REG_GRID_WIDTH)
                width = data[GRID_W_BITS-1:0];
        endfunction

        // Active columns; widths past the array saturate
        function logic [COLS-1:0] live_mask();
            int w;
            w = (width > COLS) ? COLS : int'(width);
            return (w >= COLS) ? ALL_LIVE : ((COLS'(1) << w) - COLS'(1));
        endfunction

        // Next state of a row from the (masked) rows above, itself and below
        function logic [COLS-1:0] evolve_row(logic [COLS-1:0] up, logic [COLS-1:0] mid,
                                             logic [COLS-1:0] down);
            logic [COLS+1:0] pu, pm, pd;
            logic [COLS-1:0] nxt;
            int n;
            pu = {1'b0, up, 1'b0};
            pm = {1'b0, mid, 1'b0};
            pd = {1'b0, down, 1'b0};
            for (int c = 0; c < COLS; c++)
            begin
                n = pu[c] + pu[c+1] + pu[c+2] + pm[c] + pm[c+2] + pd[c] + pd[c+1] + pd[c+2];
                nxt[c] = rule[2*n + pm[c+1]];
            end
            return nxt & live_mask();
        endfunction

        // Append one expected word at the tail
        function void add_expected(logic [COLS-1:0] cells, logic done);
            row_word_t w;
            w.cells = cells;
            w.done  = done;
            expected_rows.insert(expected_rows.size(), w);
        endfunction

        function void take_row(logic [COLS-1:0] row_in, logic last);
            logic [COLS-1:0] row;
            row = row_in & live_mask();
            if (held == 0)
            begin
                above  = '0;
                middle = row;
                held   = 1;
            end
            else
            begin
                add_expected(evolve_row(above, middle, row), 1'b0);
                above  = middle;
                middle = row;
                held   = 2;
            end
            // bottom row closes the generation against a dead row below
            if (last)
            begin
                add_expected(evolve_row(above, middle, '0), 1'b1);
                above  = '0;
                middle = '0;
                held   = 0;
            end
        endfunction

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_row(logic [COLS-1:0] cells, logic done);
            row_word_t want;
            if (expected_rows.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word cells=%h done=%b", cells, done));
                return;
            end
            want = expected_rows.pop_front();
            if (cells !== want.cells)
                report_mismatch($sformatf("cells %h, want %h", cells, want.cells));
            if (done !== want.done)
                report_mismatch($sformatf("generation_done %b, want %b", done, want.done));
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [COLS-1:0]        row_cells = '0;
    logic                   final_row = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [COLS-1:0]        next_row_cells;
    logic                   generation_done;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    generation_tracker tracker;
    int unsigned rows_sent = 0;
    int unsigned gap_odds = 0;
    int unsigned stall_odds = 0;
    int unsigned stall_left = 0;
    int unsigned quiet = 0;
    bit          calm = 1'b0;
    bit          hold_req = 1'b0;
    bit          held_off = 1'b0;

    outer_totalistic_ca_row_step dut (.*);

    always #4 clk = ~clk;

    // Receiver: check each accepted word, then decide the next cycle's stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                tracker.check_row(next_row_cells, generation_done);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!held_off && hold_req)
            begin
                // long hold-off so the output queue fills and backs up the input
                held_off   = 1'b1;
                stall_left = 79;
                out_stall <= 1'b1;
            end
            else if (!calm && stall_odds != 0 && $urandom_range(stall_odds - 1, 0) == 0)
            begin
                stall_left = $urandom_range(18, 0);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Watchdog on cycles with no handshake on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Offer one row word, with an optional idle burst first; valid stays high after
    task automatic send_row(input logic [COLS-1:0] row, input logic last);
        if (!calm && gap_odds != 0 && $urandom_range(gap_odds - 1, 0) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(19, 1)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        row_cells <= row;
        final_row <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.take_row(row, last);
        rows_sent++;
    endtask

    // Register write; valid is left high for a following write
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tracker.set_reg(idx, data);
    endtask

    // Rule, then width with junk above its 7 bits, then maybe a stray index
    task automatic program_regs(input logic [RULE_BITS-1:0] rule,
                                input logic [GRID_W_BITS-1:0] width, input bit stray);
        write_reg(REG_RULE_CODE, rule);
        write_reg(REG_GRID_WIDTH, {11'($urandom), width});
        if (stray)
            write_reg(CFG_INDEX_W'($urandom_range(REG_STRAY_LAST, REG_STRAY_FIRST)),
                      CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // Stop offering and wait for every expected word, plus a short settle
    task automatic drain_rows();
        in_valid <= 1'b0;
        while (tracker.expected_rows.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [COLS-1:0] draw_row();
        logic [COLS-1:0] a, b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(3, 0))
            0: return a & b;
            1: return a | b;
            default: return a;
        endcase
    endfunction

    function automatic logic [GRID_W_BITS-1:0] pick_width();
        case ($urandom_range(11, 0))
            0: return 7'd64;
            1: return 7'($urandom_range(127, 65));
            2: return 7'd1;
            3: return 7'd2;
            4: return 7'd3;
            5: return 7'd0;
            default: return 7'($urandom_range(64, 1));
        endcase
    endfunction

    function automatic int unsigned pick_odds();
        case ($urandom_range(2, 0))
            0: return 0;
            1: return 2;
            default: return 6;
        endcase
    endfunction

    task automatic send_generation(input int len);
        for (int r = 0; r < len; r++)
            send_row(draw_row(), r == len - 1);
    endtask

    initial
    begin
        int gens;
        int len;
        tracker = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset rule and width: single-row, two-row and four-row generations
        send_row(ALL_LIVE, 1'b1);
        send_row('0, 1'b0);
        send_row(ALL_LIVE, 1'b1);
        send_row({32{2'b01}}, 1'b0);
        send_row({32{2'b10}}, 1'b0);
        send_row(ALL_LIVE, 1'b0);
        send_row({1'b1, 62'd0, 1'b1}, 1'b1);
        drain_rows();

        // every rule bit set, width past the array, ignored indexes
        write_reg(REG_STRAY_LAST, '1);
        write_reg(REG_STRAY_FIRST, '1);
        write_reg(REG_RULE_CODE, '1);
        write_reg(REG_GRID_WIDTH, 18'd127);
        cfg_valid <= 1'b0;
        send_row('0, 1'b0);
        send_row(ALL_LIVE, 1'b1);
        drain_rows();

        // birth with no neighbors, one column, width data with high junk
        write_reg(REG_RULE_CODE, 18'h00001);
        write_reg(REG_GRID_WIDTH, 18'h3FF81);
        cfg_valid <= 1'b0;
        send_row('0, 1'b0);
        send_row(ALL_LIVE, 1'b0);
        send_row('0, 1'b1);
        drain_rows();

        // empty rule, zero width: every column dead
        program_regs('0, 7'd0, 1'b0);
        send_row(ALL_LIVE, 1'b0);
        send_row(ALL_LIVE, 1'b1);
        drain_rows();

        // survivors keep state only, odd width
        program_regs(18'h2AAAA, 7'd33, 1'b0);
        send_row(ALL_LIVE, 1'b0);
        send_row({32{2'b01}}, 1'b0);
        send_row(ALL_LIVE, 1'b1);
        drain_rows();

        // receiver holds off while a tall generation keeps coming
        hold_req = 1'b1;
        send_generation(16);
        drain_rows();

        // random phases: new settings, then several generations of random rows
        while (rows_sent < 1300)
        begin
            calm = (rows_sent >= 1150);
            gap_odds = pick_odds();
            stall_odds = pick_odds();
            program_regs(($urandom_range(3, 0) == 0) ? RULE_RESET : RULE_BITS'($urandom),
                         pick_width(), $urandom_range(3, 0) == 0);
            gens = $urandom_range(8, 2);
            for (int g = 0; g < gens; g++)
            begin
                len = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 13)
                                                  : $urandom_range(12, 1);
                send_generation(len);
            end
            drain_rows();
        end

        repeat (8) @(posedge clk);
        if (tracker.errors == 0 && tracker.expected_rows.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> outer_totalistic_ca_row_step.f
rtl/otca_pkg.sv
rtl/otca_cell.sv
rtl/otca_out_queue.sv
rtl/outer_totalistic_ca_row_step.sv
rtl/otca_checker.sv
test/outer_totalistic_ca_row_step_test.sv
